[hw/rtl/pca_pkg.sv]
// Shared types and constants for the pressure calibration and averaging block.
`timescale 1ns / 1ps

package pca_pkg;

    localparam int CODE_W  = 16;
    localparam int CAL_W   = 8;
    localparam int C10_W   = 12;
    localparam int MAG_W   = 16;
    localparam int QUOT_W  = 28;
    localparam int CNT_W   = 5;
    localparam int DEPTH   = 4;
    localparam int PTR_W   = 2;
    localparam int SUM_W   = 18;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] CFG_ZERO_OFFSET    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SPAN_OFFSET    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_CALIB_PRESSURE = 2'd2;

    localparam logic [CODE_W-1:0] ZERO_OFFSET_RST    = 16'd0;
    localparam logic [CODE_W-1:0] SPAN_OFFSET_RST    = 16'hFFFF;
    localparam logic [CAL_W-1:0]  CALIB_PRESSURE_RST = 8'd40;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic den_zero;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

[hw/rtl/pca_in_if.sv]
// Input channel interface carrying one raw converter code per transfer.
`timescale 1ns / 1ps

interface pca_in_if;
    logic                       valid;
    logic                       ready;
    logic [pca_pkg::CODE_W-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

[hw/rtl/pca_out_if.sv]
// Output channel interface carrying one calibrated result per transfer.
`timescale 1ns / 1ps

interface pca_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [pca_pkg::CODE_W-1:0] measured_pressure;
    logic signed [pca_pkg::CODE_W-1:0] filtered_pressure;
    logic        [pca_pkg::CODE_W-1:0] raw_echo;
    logic                              divide_error;

    modport source (output valid, output measured_pressure, output filtered_pressure,
                    output raw_echo, output divide_error, input ready);
    modport sink   (input valid, input measured_pressure, input filtered_pressure,
                    input raw_echo, input divide_error, output ready);
endinterface

[hw/rtl/pca_cfg_if.sv]
// Configuration write channel interface carrying a register index and data.
`timescale 1ns / 1ps

interface pca_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [pca_pkg::IDX_W-1:0]  index;
    logic [pca_pkg::CODE_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/pca_ctrl.sv]
// Controller state machine sequencing capture, multiply, divide and result load.
`timescale 1ns / 1ps

module pca_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pca_pkg::t_status i_status,
    output logic             o_in_ready,
    output pca_pkg::t_cmd    o_cmd
);

    pca_pkg::t_state r_state;
    pca_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pca_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            pca_pkg::S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = pca_pkg::S_MUL;
                end
            end
            pca_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_status.den_zero ? pca_pkg::S_FIN : pca_pkg::S_DIV;
            end
            pca_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = pca_pkg::S_FIN;
                end
            end
            pca_pkg::S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = pca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pca_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/pca_datapath.sv]
// Datapath with configuration registers, multiplier, serial divider, ring and output register.
`timescale 1ns / 1ps

module pca_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pca_pkg::t_cmd                     i_cmd,
    output pca_pkg::t_status                  o_status,
    input  logic                              i_cfg_we,
    input  logic [pca_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [pca_pkg::CODE_W-1:0]        i_cfg_data,
    input  logic [pca_pkg::CODE_W-1:0]        i_adc_code,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [pca_pkg::CODE_W-1:0] o_measured_pressure,
    output logic signed [pca_pkg::CODE_W-1:0] o_filtered_pressure,
    output logic        [pca_pkg::CODE_W-1:0] o_raw_echo,
    output logic                              o_divide_error
);

    logic [pca_pkg::CODE_W-1:0] r_zero_offset;
    logic [pca_pkg::CODE_W-1:0] r_span_offset;
    logic [pca_pkg::CAL_W-1:0]  r_calib_pressure;

    logic [pca_pkg::CODE_W-1:0] r_code;
    logic [pca_pkg::QUOT_W-1:0] r_quo;
    logic [pca_pkg::MAG_W-1:0]  r_rem;
    logic [pca_pkg::MAG_W-1:0]  r_dmag;
    logic                       r_neg;
    logic [pca_pkg::CNT_W-1:0]  r_cnt;

    logic [pca_pkg::CODE_W-1:0] r_ring [pca_pkg::DEPTH];
    logic [pca_pkg::PTR_W-1:0]  r_ptr;

    logic                       r_out_valid;
    logic [pca_pkg::CODE_W-1:0] r_out_meas;
    logic [pca_pkg::CODE_W-1:0] r_out_filt;
    logic [pca_pkg::CODE_W-1:0] r_out_raw;
    logic                       r_out_derr;

    logic [pca_pkg::CODE_W:0]   num_diff;
    logic [pca_pkg::CODE_W:0]   den_diff;
    logic [pca_pkg::CODE_W:0]   num_abs;
    logic [pca_pkg::CODE_W:0]   den_abs;
    logic [pca_pkg::C10_W-1:0]  c10;
    logic                       den_zero;
    logic [pca_pkg::MAG_W:0]    rem_sh;
    logic [pca_pkg::MAG_W:0]    rem_sub;
    logic                       q_bit;
    logic [pca_pkg::CODE_W-1:0] meas;
    logic [pca_pkg::CODE_W-1:0] entry [pca_pkg::DEPTH];
    logic signed [pca_pkg::SUM_W-1:0] sum;
    logic signed [pca_pkg::SUM_W-1:0] sum_adj;
    logic signed [pca_pkg::SUM_W-1:0] filt;

    assign num_diff = {1'b0, r_code} - {1'b0, r_zero_offset};
    assign den_diff = {1'b0, r_span_offset} - {1'b0, r_zero_offset};
    assign num_abs  = num_diff[pca_pkg::CODE_W] ? -num_diff : num_diff;
    assign den_abs  = den_diff[pca_pkg::CODE_W] ? -den_diff : den_diff;
    assign den_zero = (r_span_offset == r_zero_offset);
    assign c10      = {1'b0, r_calib_pressure, 3'b000} + {3'b000, r_calib_pressure, 1'b0};

    assign rem_sh  = {r_rem, r_quo[pca_pkg::QUOT_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dmag};
    assign q_bit   = !rem_sub[pca_pkg::MAG_W];

    assign meas = den_zero ? '0 :
                  (r_neg ? -r_quo[pca_pkg::CODE_W-1:0] : r_quo[pca_pkg::CODE_W-1:0]);

    always_comb begin
        sum = '0;
        for (int i = 0; i < pca_pkg::DEPTH; i++) begin
            entry[i] = (r_ptr == pca_pkg::PTR_W'(i)) ? meas : r_ring[i];
            sum      = sum + pca_pkg::SUM_W'(signed'(entry[i]));
        end
        sum_adj = sum + (sum[pca_pkg::SUM_W-1] ? pca_pkg::SUM_W'(pca_pkg::DEPTH - 1) : '0);
        filt    = sum_adj >>> pca_pkg::PTR_W;
    end

    assign o_status.den_zero = den_zero;
    assign o_status.div_last = (r_cnt == pca_pkg::CNT_W'(pca_pkg::QUOT_W - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset    <= pca_pkg::ZERO_OFFSET_RST;
            r_span_offset    <= pca_pkg::SPAN_OFFSET_RST;
            r_calib_pressure <= pca_pkg::CALIB_PRESSURE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pca_pkg::CFG_ZERO_OFFSET:    r_zero_offset    <= i_cfg_data;
                pca_pkg::CFG_SPAN_OFFSET:    r_span_offset    <= i_cfg_data;
                pca_pkg::CFG_CALIB_PRESSURE: r_calib_pressure <= i_cfg_data[pca_pkg::CAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_code <= i_adc_code;
        end
        if (i_cmd.mul) begin
            r_quo  <= pca_pkg::QUOT_W'(num_abs[pca_pkg::MAG_W-1:0]) * pca_pkg::QUOT_W'(c10);
            r_dmag <= den_abs[pca_pkg::MAG_W-1:0];
            r_neg  <= num_diff[pca_pkg::CODE_W] ^ den_diff[pca_pkg::CODE_W];
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.step) begin
            r_rem <= q_bit ? rem_sub[pca_pkg::MAG_W-1:0] : rem_sh[pca_pkg::MAG_W-1:0];
            r_quo <= {r_quo[pca_pkg::QUOT_W-2:0], q_bit};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pca_pkg::DEPTH; i++) begin
                r_ring[i] <= '0;
            end
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_ring[r_ptr] <= meas;
                r_ptr         <= r_ptr + 1'b1;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_meas <= meas;
            r_out_filt <= filt[pca_pkg::CODE_W-1:0];
            r_out_raw  <= r_code;
            r_out_derr <= den_zero;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_measured_pressure = r_out_meas;
    assign o_filtered_pressure = r_out_filt;
    assign o_raw_echo          = r_out_raw;
    assign o_divide_error      = r_out_derr;

endmodule

[hw/rtl/pressure_calibrate_and_average.sv]
// Top level joining the controller and datapath of the pressure calibration block.
//
//   Channel  Direction  Contents
//   i_in     in         adc_code
//   o_out    out        measured_pressure, filtered_pressure, raw_echo, divide_error
//   i_cfg    in         index, data (zero_offset, span_offset, calib_pressure)
//
// An item passes through its transfer, the multiply, the restoring divider at one quotient
// bit per cycle, and the load of the output register; the next transfer can come in the
// cycle after the load. With equal offsets the divider is skipped. Reset clears the ring,
// its pointer and the output valid flag, and loads the configuration register defaults.
// A waiting result does not block the next transfer in, but that item then holds before its
// output load, with the input not ready, until the waiting result is taken.
`timescale 1ns / 1ps

module pressure_calibrate_and_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pca_in_if.sink      i_in,
    pca_out_if.source   o_out,
    pca_cfg_if.sink     i_cfg
);

    pca_pkg::t_cmd    cmd;
    pca_pkg::t_status status;

    assign i_cfg.ready = i_rst_n;

    pca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    pca_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_we            (i_cfg.valid),
        .i_cfg_index         (i_cfg.index),
        .i_cfg_data          (i_cfg.data),
        .i_adc_code          (i_in.adc_code),
        .i_out_ready         (o_out.ready),
        .o_out_valid         (o_out.valid),
        .o_measured_pressure (o_out.measured_pressure),
        .o_filtered_pressure (o_out.filtered_pressure),
        .o_raw_echo          (o_out.raw_echo),
        .o_divide_error      (o_out.divide_error)
    );

endmodule
